// ===== sv/efg_pkg.sv =====
// ----------------------------------------------------------------------------
// Event flag group package
// Shared constants, types, the control store and the wait condition test.
// ----------------------------------------------------------------------------
`default_nettype none

package efg_pkg;

    // Sizes of the flag word and the waiter list.
    localparam int MAX_WAITERS = 16;
    localparam int FLAG_WIDTH  = 32;
    localparam int TASK_W      = 4;
    localparam int IDX_W       = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
    localparam int CNT_W       = $clog2(MAX_WAITERS + 1);
    localparam int STEP_W      = 3;

    // Command codes.
    localparam logic [1:0] CMD_INIT  = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_SET   = 2'd2;
    localparam logic [1:0] CMD_WAIT  = 2'd3;

    // Result kinds.
    localparam logic [2:0] KIND_ACK     = 3'd0;
    localparam logic [2:0] KIND_SAT     = 3'd1;
    localparam logic [2:0] KIND_FAIL    = 3'd2;
    localparam logic [2:0] KIND_PENDING = 3'd3;
    localparam logic [2:0] KIND_WOKEN   = 3'd4;

    // Step addresses of the control store. The command handlers sit in
    // command order so that a dispatch adds the command to the init step.
    localparam logic [STEP_W-1:0] S_IDLE  = 3'd0;
    localparam logic [STEP_W-1:0] S_DEC   = 3'd1;
    localparam logic [STEP_W-1:0] S_INIT  = 3'd2;
    localparam logic [STEP_W-1:0] S_CLEAR = 3'd3;
    localparam logic [STEP_W-1:0] S_SET   = 3'd4;
    localparam logic [STEP_W-1:0] S_WAIT  = 3'd5;
    localparam logic [STEP_W-1:0] S_SCAN  = 3'd6;
    localparam logic [STEP_W-1:0] S_ACK   = 3'd7;

    // One entry of the waiter list.
    typedef struct packed {
        logic [TASK_W-1:0]     task_id;
        logic [FLAG_WIDTH-1:0] mask;
        logic                  all_mode;
    } waiter_t;

    // Control word fields.
    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_ACK,
        EMIT_WAIT,
        EMIT_WAKE
    } emit_t;

    typedef enum logic [1:0] {
        FLAG_KEEP,
        FLAG_ZERO,
        FLAG_CLEAR,
        FLAG_SET
    } flag_op_t;

    typedef enum logic [2:0] {
        LIST_NONE,
        LIST_INIT,
        LIST_START,
        LIST_STEP,
        LIST_APPEND
    } list_op_t;

    typedef enum logic [1:0] {
        JUMP_NEXT,
        JUMP_ACCEPT,
        JUMP_CMD,
        JUMP_SCAN
    } jump_t;

    typedef struct packed {
        emit_t             emit;
        flag_op_t          flag_op;
        list_op_t          list_op;
        jump_t             jump;
        logic [STEP_W-1:0] target;
    } uword_t;

    // Control store: one control word per step.
    function automatic uword_t ucode_rom(input logic [STEP_W-1:0] step);
        uword_t w;
        case (step)
            S_IDLE:  w = '{EMIT_NONE, FLAG_KEEP,  LIST_NONE,   JUMP_ACCEPT, S_DEC};
            S_DEC:   w = '{EMIT_NONE, FLAG_KEEP,  LIST_NONE,   JUMP_CMD,    S_INIT};
            S_INIT:  w = '{EMIT_ACK,  FLAG_ZERO,  LIST_INIT,   JUMP_NEXT,   S_IDLE};
            S_CLEAR: w = '{EMIT_NONE, FLAG_CLEAR, LIST_NONE,   JUMP_NEXT,   S_ACK};
            S_SET:   w = '{EMIT_NONE, FLAG_SET,   LIST_START,  JUMP_NEXT,   S_SCAN};
            S_WAIT:  w = '{EMIT_WAIT, FLAG_KEEP,  LIST_APPEND, JUMP_NEXT,   S_IDLE};
            S_SCAN:  w = '{EMIT_WAKE, FLAG_KEEP,  LIST_STEP,   JUMP_SCAN,   S_ACK};
            S_ACK:   w = '{EMIT_ACK,  FLAG_KEEP,  LIST_NONE,   JUMP_NEXT,   S_IDLE};
            default: w = '{EMIT_NONE, FLAG_KEEP,  LIST_NONE,   JUMP_NEXT,   S_IDLE};
        endcase
        return w;
    endfunction

    // ALL holds when every mask bit is set; ANY when at least one is set.
    function automatic logic cond_holds(input logic [FLAG_WIDTH-1:0] flags,
                                        input logic [FLAG_WIDTH-1:0] mask,
                                        input logic                  all_mode);
        logic r;
        if (all_mode)
            r = ((flags & mask) == mask);
        else
            r = ((flags & mask) != '0);
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/efg_waiter_list.sv =====
// ----------------------------------------------------------------------------
// Event flag group waiter list
// Storage for the waiting tasks: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module efg_waiter_list (
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [efg_pkg::IDX_W-1:0]     wr_addr,
    input  wire efg_pkg::waiter_t              wr_data,
    input  wire logic                          rd_en,
    input  wire logic [efg_pkg::IDX_W-1:0]     rd_addr,
    output efg_pkg::waiter_t                   rd_data
);

    efg_pkg::waiter_t mem [efg_pkg::MAX_WAITERS];
    efg_pkg::waiter_t rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/event_flag_group_unit.sv =====
// ----------------------------------------------------------------------------
// Event flag group unit
// A 32-bit event flag word with an ordered list of waiting tasks.
// ----------------------------------------------------------------------------
// Commands are taken one at a time. Init, clear and wait produce one beat; a
// set ORs in its bits, then checks every waiter in arrival order at one
// waiter per cycle while no woken beat waits on a stalled output, producing
// a woken beat for each waiter whose condition holds and closing with an
// acknowledge beat. A step that emits a beat waits while the output is
// stalled. The input channel stalls while a command is in progress; the
// output beat sits in its own register, so a new command can start while
// the last beat is held.
`default_nettype none

module event_flag_group_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Command channel.
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [1:0]                      command,
    input  wire logic [efg_pkg::FLAG_WIDTH-1:0]  bits,
    input  wire logic                            match_all,
    input  wire logic                            may_block,
    input  wire logic [efg_pkg::TASK_W-1:0]      task_number,
    input  wire logic                            caller_can_wait,
    // Result channel.
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [2:0]                           kind,
    output logic [efg_pkg::TASK_W-1:0]           woken_task,
    output logic [efg_pkg::FLAG_WIDTH-1:0]       flag_word,
    output logic                                 reschedule,
    output logic                                 last_result
);

    // Sequencer and datapath registers.
    logic [efg_pkg::STEP_W-1:0]     step_reg,  step_next;
    logic [efg_pkg::FLAG_WIDTH-1:0] flags_reg, flags_next;
    logic [efg_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [efg_pkg::CNT_W-1:0]      idx_reg,   idx_next;
    logic [efg_pkg::CNT_W-1:0]      kept_reg,  kept_next;
    logic                           awoke_reg, awoke_next;

    // Latched command.
    logic [1:0]                     cmd_reg;
    logic [efg_pkg::FLAG_WIDTH-1:0] bits_reg;
    logic                           all_reg;
    logic                           block_reg;
    logic [efg_pkg::TASK_W-1:0]     task_reg;
    logic                           can_wait_reg;

    // Output register.
    logic                           out_valid_reg, out_valid_next;
    logic [2:0]                     kind_reg;
    logic [efg_pkg::TASK_W-1:0]     task_out_reg;
    logic [efg_pkg::FLAG_WIDTH-1:0] flag_out_reg;
    logic                           resched_reg;
    logic                           last_reg;

    // Control and memory signals.
    efg_pkg::uword_t                uw;
    efg_pkg::waiter_t               rd_data;
    efg_pkg::waiter_t               wr_data;
    logic                           wr_en;
    logic [efg_pkg::IDX_W-1:0]      wr_addr;
    logic                           rd_en;
    logic [efg_pkg::IDX_W-1:0]      rd_addr;
    logic                           accept;
    logic                           out_free;
    logic                           scan_done;
    logic                           hit;
    logic                           need_out;
    logic                           fire;
    logic [2:0]                     wait_kind;
    logic [2:0]                     emit_kind;
    logic [efg_pkg::TASK_W-1:0]     emit_task;
    logic [efg_pkg::CNT_W-1:0]      idx_inc;

    efg_waiter_list u_list (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Fetch the control word and derive the step conditions.
    always_comb
    begin
        uw        = efg_pkg::ucode_rom(step_reg);
        accept    = in_valid && (step_reg == efg_pkg::S_IDLE);
        out_free  = !out_valid_reg || !out_stall;
        scan_done = (idx_reg == count_reg);
        hit       = efg_pkg::cond_holds(flags_reg, rd_data.mask, rd_data.all_mode);
        idx_inc   = idx_reg + efg_pkg::CNT_W'(1);
    end

    // Decide the outcome of a wait command.
    always_comb
    begin
        if (!can_wait_reg)
            wait_kind = efg_pkg::KIND_SAT;
        else if (efg_pkg::cond_holds(flags_reg, bits_reg, all_reg))
            wait_kind = efg_pkg::KIND_SAT;
        else if (!block_reg)
            wait_kind = efg_pkg::KIND_FAIL;
        else if (count_reg == efg_pkg::CNT_W'(efg_pkg::MAX_WAITERS))
            wait_kind = efg_pkg::KIND_FAIL;
        else
            wait_kind = efg_pkg::KIND_PENDING;
    end

    // Beat to emit this step; a step that emits waits for a free output slot.
    always_comb
    begin
        case (uw.emit)
            efg_pkg::EMIT_NONE: need_out = 1'b0;
            efg_pkg::EMIT_WAKE: need_out = !scan_done && hit;
            default:            need_out = 1'b1;
        endcase
        fire = !need_out || out_free;

        case (uw.emit)
            efg_pkg::EMIT_WAIT:
            begin
                emit_kind = wait_kind;
                emit_task = (wait_kind == efg_pkg::KIND_PENDING) ? task_reg : '0;
            end
            efg_pkg::EMIT_WAKE:
            begin
                emit_kind = efg_pkg::KIND_WOKEN;
                emit_task = rd_data.task_id;
            end
            default:
            begin
                emit_kind = efg_pkg::KIND_ACK;
                emit_task = '0;
            end
        endcase
    end

    // Flag word update.
    always_comb
    begin
        case (uw.flag_op)
            efg_pkg::FLAG_ZERO:  flags_next = '0;
            efg_pkg::FLAG_CLEAR: flags_next = flags_reg & ~bits_reg;
            efg_pkg::FLAG_SET:   flags_next = flags_reg | bits_reg;
            default:             flags_next = flags_reg;
        endcase
    end

    // Waiter list control: scan, compaction and append.
    always_comb
    begin
        count_next = count_reg;
        idx_next   = idx_reg;
        kept_next  = kept_reg;
        awoke_next = accept ? 1'b0 : awoke_reg;
        wr_en      = 1'b0;
        wr_addr    = kept_reg[efg_pkg::IDX_W-1:0];
        wr_data    = rd_data;
        rd_en      = 1'b0;
        rd_addr    = '0;
        case (uw.list_op)
            efg_pkg::LIST_INIT:
            begin
                count_next = '0;
            end
            efg_pkg::LIST_START:
            begin
                idx_next  = '0;
                kept_next = '0;
                rd_en     = 1'b1;
            end
            efg_pkg::LIST_STEP:
            begin
                if (scan_done)
                begin
                    count_next = kept_reg;
                end
                else if (fire)
                begin
                    idx_next = idx_inc;
                    rd_en    = 1'b1;
                    rd_addr  = idx_inc[efg_pkg::IDX_W-1:0];
                    if (hit)
                    begin
                        awoke_next = 1'b1;
                    end
                    else
                    begin
                        wr_en     = 1'b1;
                        kept_next = kept_reg + efg_pkg::CNT_W'(1);
                    end
                end
            end
            efg_pkg::LIST_APPEND:
            begin
                if (fire && (wait_kind == efg_pkg::KIND_PENDING))
                begin
                    wr_en      = 1'b1;
                    wr_addr    = count_reg[efg_pkg::IDX_W-1:0];
                    wr_data    = '{task_reg, bits_reg, all_reg};
                    count_next = count_reg + efg_pkg::CNT_W'(1);
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // Step counter with conditional jumps.
    always_comb
    begin
        step_next = step_reg;
        if (fire)
        begin
            case (uw.jump)
                efg_pkg::JUMP_NEXT:   step_next = uw.target;
                efg_pkg::JUMP_ACCEPT: step_next = accept ? uw.target : step_reg;
                efg_pkg::JUMP_CMD:
                    step_next = uw.target + efg_pkg::STEP_W'(cmd_reg);
                efg_pkg::JUMP_SCAN:   step_next = scan_done ? uw.target : step_reg;
                default:              step_next = efg_pkg::S_IDLE;
            endcase
        end
    end

    // Output valid: set on a new beat, dropped once the beat is taken.
    always_comb
    begin
        if (fire && need_out)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= efg_pkg::S_IDLE;
            flags_reg     <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            kept_reg      <= '0;
            awoke_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            flags_reg     <= flags_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            kept_reg      <= kept_next;
            awoke_reg     <= awoke_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Command and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg      <= command;
            bits_reg     <= bits;
            all_reg      <= match_all;
            block_reg    <= may_block;
            task_reg     <= task_number;
            can_wait_reg <= caller_can_wait;
        end
        if (fire && need_out)
        begin
            kind_reg     <= emit_kind;
            task_out_reg <= emit_task;
            flag_out_reg <= flags_next;
            resched_reg  <= (uw.emit == efg_pkg::EMIT_ACK) && awoke_reg;
            last_reg     <= (uw.emit != efg_pkg::EMIT_WAKE);
        end
    end

    assign in_stall    = (step_reg != efg_pkg::S_IDLE);
    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign woken_task  = task_out_reg;
    assign flag_word   = flag_out_reg;
    assign reschedule  = resched_reg;
    assign last_result = last_reg;

`ifndef SYNTHESIS
    // The list never holds more waiters than it has room for.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= efg_pkg::CNT_W'(efg_pkg::MAX_WAITERS))
        else $error("waiter count exceeds the list size");

    // Compaction never writes ahead of the read position.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == efg_pkg::S_SCAN) |-> (kept_reg <= idx_reg && idx_reg <= count_reg))
        else $error("scan indexes out of order");

    // A woken beat is never the final beat and never asks for a reschedule.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == efg_pkg::KIND_WOKEN) |-> (!last_result && !reschedule))
        else $error("woken beat marked final or rescheduling");

    // An accepted command moves on to the dispatch step in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (step_reg == efg_pkg::S_DEC))
        else $error("accepted command did not enter dispatch");
`endif

endmodule

`default_nettype wire

// ===== test/event_flag_group_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Event flag group unit testbench
// A queue of commands feeds a clocked driver, and a clocked monitor checks
// every result beat against a cycle-free model of the flag word and the
// waiter list. The run starts with directed commands, including a full
// waiter list, and then sends weighted random commands. Idling and stalls
// change in phases, and one long output hold-off fills the block up.
// ----------------------------------------------------------------------------
`default_nettype none

module event_flag_group_unit_test;

    // Run length and pressure settings.
    localparam int RANDOM_CMDS = 500;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_AT = 200;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_LEN = 64;

    // One command beat with a flag that makes the sender drain first.
    typedef struct {
        logic [1:0]                     command;
        logic [efg_pkg::FLAG_WIDTH-1:0] bits;
        logic                           match_all;
        logic                           may_block;
        logic [efg_pkg::TASK_W-1:0]     task_number;
        logic                           caller_can_wait;
        logic                           drain_first;
    } cmd_beat_t;

    // One expected result beat.
    typedef struct {
        logic [2:0]                     kind;
        logic [efg_pkg::TASK_W-1:0]     woken_task;
        logic [efg_pkg::FLAG_WIDTH-1:0] flag_word;
        logic                           reschedule;
        logic                           last_result;
    } result_beat_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    wire logic                      in_stall;
    logic [1:0]                     command = efg_pkg::CMD_INIT;
    logic [efg_pkg::FLAG_WIDTH-1:0] bits = '0;
    logic                           match_all = 1'b0;
    logic                           may_block = 1'b0;
    logic [efg_pkg::TASK_W-1:0]     task_number = '0;
    logic                           caller_can_wait = 1'b0;
    wire logic                      out_valid;
    logic                           out_stall = 1'b0;
    wire logic [2:0]                kind;
    wire logic [efg_pkg::TASK_W-1:0] woken_task;
    wire logic [efg_pkg::FLAG_WIDTH-1:0] flag_word;
    wire logic                      reschedule;
    wire logic                      last_result;

    cmd_beat_t    pending_cmds[$];
    result_beat_t expected_beats[$];

    // Model state: flag word and the ordered waiter list.
    logic [efg_pkg::FLAG_WIDTH-1:0] model_flags = '0;
    efg_pkg::waiter_t               model_waiters[efg_pkg::MAX_WAITERS];
    int                             model_count = 0;

    int accepted_count = 0;
    int beats_checked = 0;
    int wakes_predicted = 0;
    int full_list_fails = 0;
    int error_count = 0;
    int hold_left = 0;
    logic hold_done = 1'b0;
    int cycle_count = 0;
    int send_idle_pct;
    int recv_stall_pct;

    event_flag_group_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .bits            (bits),
        .match_all       (match_all),
        .may_block       (may_block),
        .task_number     (task_number),
        .caller_can_wait (caller_can_wait),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .kind            (kind),
        .woken_task      (woken_task),
        .flag_word       (flag_word),
        .reschedule      (reschedule),
        .last_result     (last_result)
    );

    // Free-running clock, 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Idle phases: none, sender idle, receiver stalling, both lightly.
    always_comb
    begin
        case ((accepted_count / PHASE_LEN) % 4)
            1:       begin send_idle_pct = 60; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 60; end
            3:       begin send_idle_pct = 13; recv_stall_pct = 13; end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    end

    // Wait condition: ALL needs every mask bit, ANY needs at least one.
    function automatic logic waiter_ready(input logic [efg_pkg::FLAG_WIDTH-1:0] flags,
                                          input logic [efg_pkg::FLAG_WIDTH-1:0] mask,
                                          input logic all_mode);
        if (all_mode)
            return (flags & mask) == mask;
        return (flags & mask) != '0;
    endfunction

    // Queue one expected beat that carries the current model flags.
    task automatic push_result(input logic [2:0] k, input logic [efg_pkg::TASK_W-1:0] t,
                               input logic resched, input logic last);
        result_beat_t r;
        r.kind = k;
        r.woken_task = t;
        r.flag_word = model_flags;
        r.reschedule = resched;
        r.last_result = last;
        expected_beats.push_back(r);
    endtask

    // Apply one accepted command to the model and queue its result beats.
    task automatic apply_flag_command(input cmd_beat_t c);
        int   kept;
        logic awoke;
        kept = 0;
        awoke = 1'b0;
        case (c.command)
            efg_pkg::CMD_INIT:
            begin
                model_flags = '0;
                model_count = 0;
                push_result(efg_pkg::KIND_ACK, '0, 1'b0, 1'b1);
            end
            efg_pkg::CMD_CLEAR:
            begin
                model_flags = model_flags & ~c.bits;
                push_result(efg_pkg::KIND_ACK, '0, 1'b0, 1'b1);
            end
            efg_pkg::CMD_SET:
            begin
                // Wake satisfied waiters in order and compact the rest.
                model_flags = model_flags | c.bits;
                for (int i = 0; i < model_count; i++)
                begin
                    if (waiter_ready(model_flags, model_waiters[i].mask,
                                     model_waiters[i].all_mode))
                    begin
                        push_result(efg_pkg::KIND_WOKEN, model_waiters[i].task_id,
                                    1'b0, 1'b0);
                        awoke = 1'b1;
                        wakes_predicted++;
                    end
                    else
                    begin
                        model_waiters[kept] = model_waiters[i];
                        kept++;
                    end
                end
                model_count = kept;
                push_result(efg_pkg::KIND_ACK, '0, awoke, 1'b1);
            end
            default:
            begin
                if (!c.caller_can_wait)
                    push_result(efg_pkg::KIND_SAT, '0, 1'b0, 1'b1);
                else if (waiter_ready(model_flags, c.bits, c.match_all))
                    push_result(efg_pkg::KIND_SAT, '0, 1'b0, 1'b1);
                else if (!c.may_block)
                    push_result(efg_pkg::KIND_FAIL, '0, 1'b0, 1'b1);
                else if (model_count >= efg_pkg::MAX_WAITERS)
                begin
                    push_result(efg_pkg::KIND_FAIL, '0, 1'b0, 1'b1);
                    full_list_fails++;
                end
                else
                begin
                    model_waiters[model_count].task_id = c.task_number;
                    model_waiters[model_count].mask = c.bits;
                    model_waiters[model_count].all_mode = c.match_all;
                    model_count++;
                    push_result(efg_pkg::KIND_PENDING, c.task_number, 1'b0, 1'b1);
                end
            end
        endcase
    endtask

    // Report one field of a result beat that differs from the model.
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    task automatic add_cmd(input logic [1:0] cmd, input logic [efg_pkg::FLAG_WIDTH-1:0] b,
                           input logic all, input logic blk,
                           input logic [efg_pkg::TASK_W-1:0] t,
                           input logic can_wait, input logic drain);
        cmd_beat_t c;
        c.command = cmd;
        c.bits = b;
        c.match_all = all;
        c.may_block = blk;
        c.task_number = t;
        c.caller_can_wait = can_wait;
        c.drain_first = drain;
        pending_cmds.push_back(c);
    endtask

    // Random bit pattern: dense, one-hot, sparse, or the extremes.
    function automatic logic [efg_pkg::FLAG_WIDTH-1:0] random_bits();
        case ($urandom_range(5))
            0:       return $urandom();
            1:       return 32'h1 << $urandom_range(31);
            2:       return $urandom() & $urandom() & $urandom();
            3:       return $urandom() & $urandom();
            4:       return '1;
            default: return '0;
        endcase
    endfunction

    // Driver: model the accepted beat, then offer the next one or idle.
    always @(posedge clk)
    begin : driver
        cmd_beat_t nxt;
        logic      go;
        go = 1'b0;
        if (in_valid && !in_stall)
        begin
            apply_flag_command(cmd_beat_t'{command, bits, match_all, may_block,
                                           task_number, caller_can_wait, 1'b0});
            accepted_count <= accepted_count + 1;
        end
        if (rst_n && (!in_valid || !in_stall))
        begin
            if (pending_cmds.size() != 0)
            begin
                go = 1'b1;
                if (pending_cmds[0].drain_first && expected_beats.size() != 0)
                    go = 1'b0;
                if (hold_left == 0 && $urandom_range(99) < send_idle_pct)
                    go = 1'b0;
            end
            if (go)
            begin
                nxt = pending_cmds.pop_front();
                in_valid <= 1'b1;
                command <= nxt.command;
                bits <= nxt.bits;
                match_all <= nxt.match_all;
                may_block <= nxt.may_block;
                task_number <= nxt.task_number;
                caller_can_wait <= nxt.caller_can_wait;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus one long hold-off while commands keep coming.
    always @(posedge clk)
    begin : receiver
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && accepted_count >= HOLD_AT)
        begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Monitor: compare every accepted result beat with the oldest expectation.
    always @(posedge clk)
    begin : monitor
        result_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            beats_checked++;
            if (expected_beats.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, actual kind %0d task %0d flags %0h",
                         $time, kind, woken_task, flag_word);
                error_count++;
            end
            else
            begin
                want = expected_beats.pop_front();
                check_field("kind", 32'(want.kind), 32'(kind));
                check_field("woken_task", 32'(want.woken_task), 32'(woken_task));
                check_field("flag_word", 32'(want.flag_word), 32'(flag_word));
                check_field("reschedule", 32'(want.reschedule), 32'(reschedule));
                check_field("last_result", 32'(want.last_result), 32'(last_result));
            end
        end
    end

    // Watchdog on the whole run.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    // Stimulus and end of run.
    initial
    begin : stimulus
        logic [1:0] cmd;
        logic [efg_pkg::FLAG_WIDTH-1:0] b;
        int pick;

        // Empty masks, a caller that may not wait, and a non-blocking miss.
        add_cmd(efg_pkg::CMD_INIT, '0, 1'b0, 1'b0, 4'd0, 1'b1, 1'b0);
        add_cmd(efg_pkg::CMD_WAIT, '0, 1'b0, 1'b0, 4'd1, 1'b1, 1'b0);
        add_cmd(efg_pkg::CMD_WAIT, '0, 1'b1, 1'b1, 4'd2, 1'b1, 1'b0);
        add_cmd(efg_pkg::CMD_WAIT, '1, 1'b1, 1'b1, 4'd3, 1'b0, 1'b0);
        add_cmd(efg_pkg::CMD_WAIT, '1, 1'b1, 1'b0, 4'd4, 1'b1, 1'b0);
        add_cmd(efg_pkg::CMD_SET, '0, 1'b0, 1'b0, 4'd0, 1'b1, 1'b0);
        // Fill the waiter list, then try one more blocking wait.
        for (int i = 0; i < efg_pkg::MAX_WAITERS; i++)
            add_cmd(efg_pkg::CMD_WAIT, 32'h3 << (2 * i), i[0], 1'b1,
                    i[efg_pkg::TASK_W-1:0], 1'b1, 1'b0);
        add_cmd(efg_pkg::CMD_WAIT, '1, 1'b1, 1'b1, 4'd5, 1'b1, 1'b0);
        // Partial wake, clear all, wake everything left, then reset the list.
        add_cmd(efg_pkg::CMD_SET, 32'h0000_00FF, 1'b0, 1'b0, 4'd0, 1'b1, 1'b0);
        add_cmd(efg_pkg::CMD_CLEAR, '1, 1'b0, 1'b0, 4'd0, 1'b1, 1'b0);
        add_cmd(efg_pkg::CMD_SET, '1, 1'b0, 1'b0, 4'd0, 1'b1, 1'b0);
        add_cmd(efg_pkg::CMD_INIT, '0, 1'b0, 1'b0, 4'd0, 1'b1, 1'b0);

        // Random part, weighted toward waits and sets that keep the list busy.
        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 3)
                cmd = efg_pkg::CMD_INIT;
            else if (pick < 22)
                cmd = efg_pkg::CMD_CLEAR;
            else if (pick < 47)
                cmd = efg_pkg::CMD_SET;
            else
                cmd = efg_pkg::CMD_WAIT;
            b = random_bits();
            if (cmd == efg_pkg::CMD_CLEAR && $urandom_range(1))
                b = $urandom() | $urandom();
            add_cmd(cmd, b, 1'($urandom_range(1)), $urandom_range(99) < 85,
                    4'($urandom_range(15)), $urandom_range(99) < 90,
                    n == 0 || n == 350);
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || in_valid || expected_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d commands and checked %0d result beats in %0d cycles.",
                 accepted_count, beats_checked, cycle_count);
        $display("Model predicted %0d wakes and %0d blocking waits refused on a full list.",
                 wakes_predicted, full_list_fails);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/efg_pkg.sv
sv/efg_waiter_list.sv
sv/event_flag_group_unit.sv
test/event_flag_group_unit_test.sv
